FILE: rtl/core/lsps_pkg.sv
package lsps_pkg;

   localparam int SUM_WIDTH = 16;
   localparam int GAIN_W    = 9;
   localparam int SPEED_W   = 8;
   localparam int ERR_W     = 4;
   localparam int CTRL_W    = 16;
   localparam int CSR_DATA_W = 9;
   localparam int CSR_IDX_W = 2;
   localparam int PD_PROD_W = 14;
   localparam int I_PROD_W  = SUM_WIDTH + GAIN_W + 1;

   localparam logic [SPEED_W-1:0] REF_SPEED_RESET  = 8'd180;
   localparam logic [GAIN_W-1:0]  PROP_GAIN_RESET  = 9'd16;
   localparam logic [GAIN_W-1:0]  INTEG_GAIN_RESET = 9'd0;
   localparam logic [GAIN_W-1:0]  DERIV_GAIN_RESET = 9'd3;

   typedef logic signed [ERR_W-1:0] error_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REF_SPEED  = 2'd0,
      CSR_PROP_GAIN  = 2'd1,
      CSR_INTEG_GAIN = 2'd2,
      CSR_DERIV_GAIN = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] prop;
      logic [GAIN_W-1:0] integ;
      logic [GAIN_W-1:0] deriv;
   } gains_type;

   typedef struct packed {
      error_type                    error;
      logic                         active;
      logic signed [PD_PROD_W-1:0]  p_prod;
      logic signed [I_PROD_W-1:0]   i_prod;
      logic signed [PD_PROD_W-1:0]  d_prod;
   } prod_type;

   typedef struct packed {
      logic [SPEED_W-1:0]        left_drive;
      logic [SPEED_W-1:0]        right_drive;
      error_type                 line_error;
      logic signed [CTRL_W-1:0]  control_value;
   } result_type;

endpackage

FILE: rtl/core/lsps_error_decode.sv
module lsps_error_decode
   import lsps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic [7:0]        sensor_bits,
   output error_type         error
);

   error_type held_error_ff;
   error_type held_error_in;
   error_type rule_error;
   logic      matched;

   always_comb begin
      matched    = 1'b1;
      rule_error = '0;
      if (sensor_bits[4] && sensor_bits[3]) begin
         rule_error = 4'sd0;
      end else if (sensor_bits[3] && sensor_bits[2]) begin
         rule_error = -4'sd1;
      end else if (sensor_bits[4] && sensor_bits[5]) begin
         rule_error = 4'sd1;
      end else if (sensor_bits[2] && sensor_bits[1]) begin
         rule_error = -4'sd1;
      end else if (sensor_bits[5] && sensor_bits[6]) begin
         rule_error = 4'sd1;
      end else if (sensor_bits[1] && sensor_bits[0]) begin
         rule_error = -4'sd3;
      end else if (sensor_bits[6] && sensor_bits[7]) begin
         rule_error = 4'sd3;
      end else if (sensor_bits[0]) begin
         rule_error = -4'sd4;
      end else if (sensor_bits[7]) begin
         rule_error = 4'sd4;
      end else begin
         matched = 1'b0;
      end
   end

   assign error = matched ? rule_error : held_error_ff;
   assign held_error_in = (load && matched) ? rule_error : held_error_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_error_ff <= '0;
      end else begin
         held_error_ff <= held_error_in;
      end
   end

endmodule

FILE: rtl/core/lsps_pid_stage.sv
module lsps_pid_stage
   import lsps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  error_type  error,
   input  gains_type  gains,
   output prod_type   prod
);

   logic signed [SUM_WIDTH-1:0] error_sum_ff;
   logic signed [SUM_WIDTH-1:0] error_sum_in;
   logic signed [SUM_WIDTH-1:0] sum_sat;
   logic signed [SUM_WIDTH:0]   sum_wide;
   error_type                   previous_error_ff;
   error_type                   previous_error_in;
   logic signed [ERR_W:0]       error_diff;
   logic                        active;
   prod_type                    prod_ff;
   prod_type                    prod_in;

   assign active   = (error != '0);
   assign sum_wide = (SUM_WIDTH+1)'(error_sum_ff) + (SUM_WIDTH+1)'(error);

   always_comb begin
      if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
         sum_sat = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                       : {1'b0, {(SUM_WIDTH-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_WIDTH-1:0];
      end
   end

   assign error_diff = (ERR_W+1)'(error) - (ERR_W+1)'(previous_error_ff);

   always_comb begin
      prod_in.error  = error;
      prod_in.active = active;
      prod_in.p_prod = PD_PROD_W'($signed({1'b0, gains.prop}) * PD_PROD_W'(error));
      prod_in.i_prod = I_PROD_W'($signed({1'b0, gains.integ}) * I_PROD_W'(sum_sat));
      prod_in.d_prod = PD_PROD_W'($signed({1'b0, gains.deriv}) * PD_PROD_W'(error_diff));
   end

   assign error_sum_in      = (load && active) ? sum_sat : error_sum_ff;
   assign previous_error_in = (load && active) ? error : previous_error_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff      <= '0;
         previous_error_ff <= '0;
      end else begin
         error_sum_ff      <= error_sum_in;
         previous_error_ff <= previous_error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

FILE: rtl/core/lsps_mix.sv
module lsps_mix
   import lsps_pkg::*;
(
   input  prod_type            prod,
   input  logic [SPEED_W-1:0]  reference_speed,
   output result_type          result
);

   localparam int TOT_W = I_PROD_W + 2;
   localparam int SPD_W = CTRL_W + 2;
   localparam logic signed [TOT_W-1:0] CTRL_MAX = TOT_W'(32767);
   localparam logic signed [TOT_W-1:0] CTRL_MIN = -TOT_W'(32768);
   localparam logic signed [SPD_W-1:0] SPEED_MAX = SPD_W'(255);

   logic signed [PD_PROD_W-1:0] p_half;
   logic signed [I_PROD_W-1:0]  i_half;
   logic signed [PD_PROD_W-1:0] d_half;
   logic signed [TOT_W-1:0]     total;
   logic signed [CTRL_W-1:0]    control;
   logic signed [SPD_W-1:0]     ref_s;
   logic signed [SPD_W-1:0]     ctrl_s;
   logic signed [SPD_W-1:0]     left_clamp;
   logic signed [SPD_W-1:0]     right_clamp;
   logic signed [SPD_W-1:0]     left_raw;
   logic signed [SPD_W-1:0]     right_raw;

   assign p_half = (prod.p_prod
                    + $signed({{(PD_PROD_W-1){1'b0}}, prod.p_prod[PD_PROD_W-1]})) >>> 1;
   assign i_half = (prod.i_prod
                    + $signed({{(I_PROD_W-1){1'b0}}, prod.i_prod[I_PROD_W-1]})) >>> 1;
   assign d_half = (prod.d_prod
                    + $signed({{(PD_PROD_W-1){1'b0}}, prod.d_prod[PD_PROD_W-1]})) >>> 1;

   assign total = TOT_W'(p_half) + TOT_W'(i_half) + TOT_W'(d_half);

   always_comb begin
      if (total > CTRL_MAX) begin
         control = CTRL_MAX[CTRL_W-1:0];
      end else if (total < CTRL_MIN) begin
         control = CTRL_MIN[CTRL_W-1:0];
      end else begin
         control = total[CTRL_W-1:0];
      end
   end

   assign ref_s       = $signed({{(SPD_W-SPEED_W){1'b0}}, reference_speed});
   assign ctrl_s      = SPD_W'(control);
   assign left_clamp  = (ctrl_s > ref_s) ? ref_s : ctrl_s;
   assign right_clamp = (ctrl_s < -ref_s) ? -ref_s : ctrl_s;
   assign left_raw    = ref_s - left_clamp;
   assign right_raw   = ref_s + right_clamp;

   always_comb begin
      result.line_error = prod.error;
      if (prod.active) begin
         result.control_value = control;
         result.left_drive    = (left_raw > SPEED_MAX) ? 8'hFF : left_raw[SPEED_W-1:0];
         result.right_drive   = (right_raw > SPEED_MAX) ? 8'hFF : right_raw[SPEED_W-1:0];
      end else begin
         result.control_value = '0;
         result.left_drive    = reference_speed;
         result.right_drive   = reference_speed;
      end
   end

endmodule

FILE: rtl/core/line_sensor_pid_steering.sv
// Line sensor PID steering controller.
// The req channel carries one beat per control step: an 8-bit sensor sample,
// where bit i set means sensor i sees the line. The rsp channel returns one
// beat per request, in order, with the left and right motor codes, the line
// error used and the saturated PID control value.
// A request beat is registered, then the error decode, error sum update and
// the three gain products fill the product register, and the sum, clamp and
// speed logic fills the result register from the product register.
// One beat per cycle is sustained while rsp_stall is low; the error sum and
// previous error update as a beat enters the product register, when its
// error is nonzero.
// The csr port writes the reference speed and the three gains, index 0 to 3.
// Write it only while no beat is in flight.
// Reset returns the registers to their defaults, clears the held error, the
// error sum and the previous error, and empties the pipeline.
// When rsp_stall is high the result holds; the two inner stages keep filling
// and req_stall rises only once every stage is occupied.
module line_sensor_pid_steering
   import lsps_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_sensor_bits,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [SPEED_W-1:0]       rsp_left_drive,
   output logic [SPEED_W-1:0]       rsp_right_drive,
   output logic signed [ERR_W-1:0]  rsp_line_error,
   output logic signed [CTRL_W-1:0] rsp_control_value,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_write_data
);

   logic [SPEED_W-1:0] ref_speed_ff;
   logic [SPEED_W-1:0] ref_speed_in;
   gains_type          gains_ff;
   gains_type          gains_in;

   logic       s0_valid_ff;
   logic       s0_valid_in;
   logic [7:0] s0_sensor_ff;
   logic       s1_valid_ff;
   logic       s1_valid_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_ff;

   logic       out_ready;
   logic       s1_ready;
   logic       s0_ready;
   logic       req_fire;
   logic       s1_load;
   logic       out_load;

   error_type  error;
   prod_type   prod;
   result_type result;

   always_comb begin
      ref_speed_in = ref_speed_ff;
      gains_in     = gains_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_REF_SPEED:  ref_speed_in   = csr_write_data[SPEED_W-1:0];
            CSR_PROP_GAIN:  gains_in.prop  = csr_write_data[GAIN_W-1:0];
            CSR_INTEG_GAIN: gains_in.integ = csr_write_data[GAIN_W-1:0];
            CSR_DERIV_GAIN: gains_in.deriv = csr_write_data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_speed_ff   <= REF_SPEED_RESET;
         gains_ff.prop  <= PROP_GAIN_RESET;
         gains_ff.integ <= INTEG_GAIN_RESET;
         gains_ff.deriv <= DERIV_GAIN_RESET;
      end else begin
         ref_speed_ff <= ref_speed_in;
         gains_ff     <= gains_in;
      end
   end

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign s0_ready  = !s0_valid_ff || s1_ready;
   assign req_fire  = req_valid && s0_ready;
   assign s1_load   = s0_valid_ff && s1_ready;
   assign out_load  = s1_valid_ff && out_ready;

   assign s0_valid_in  = req_fire || (s0_valid_ff && !s1_ready);
   assign s1_valid_in  = s1_load || (s1_valid_ff && !out_ready);
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s0_sensor_ff <= req_sensor_bits;
      end
      if (out_load) begin
         rsp_ff <= result;
      end
   end

   lsps_error_decode u_error (
      .clock       (clock),
      .reset       (reset),
      .load        (s1_load),
      .sensor_bits (s0_sensor_ff),
      .error       (error)
   );

   lsps_pid_stage u_pid (
      .clock (clock),
      .reset (reset),
      .load  (s1_load),
      .error (error),
      .gains (gains_ff),
      .prod  (prod)
   );

   lsps_mix u_mix (
      .prod            (prod),
      .reference_speed (ref_speed_ff),
      .result          (result)
   );

   assign req_stall         = !s0_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_drive    = rsp_ff.left_drive;
   assign rsp_right_drive   = rsp_ff.right_drive;
   assign rsp_line_error    = rsp_ff.line_error;
   assign rsp_control_value = rsp_ff.control_value;

   a_error_range: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (prod.error >= -4'sd4) && (prod.error <= 4'sd4))
      else $error("line error out of range");

   a_zero_error_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.line_error == '0) |->
         (rsp_ff.control_value == '0) && (rsp_ff.left_drive == rsp_ff.right_drive))
      else $error("zero error must give zero control and equal speeds");

   a_steer_side: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.control_value > 0) |->
         (rsp_ff.left_drive <= rsp_ff.right_drive))
      else $error("positive control must not slow the right motor below the left");

   a_free_slot_takes: assert property (@(posedge clock) disable iff (reset)
      !s0_valid_ff |-> !req_stall)
      else $error("request stalled with an empty input stage");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_ready) |=> rsp_valid_ff)
      else $error("result lost between stage and result register");

endmodule

FILE: tb/line_sensor_pid_steering_tb.sv
`timescale 1ns / 1ps

module line_sensor_pid_steering_tb;
   import lsps_pkg::*;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_pattern_type;

   localparam int RANDOM_PHASES = 4;
   localparam int ITEMS_PER_PHASE = 75;
   localparam int EXTREME_ITEMS = 40;
   localparam int SUM_UP_ITEMS = 20;
   localparam int SUM_DOWN_ITEMS = 30;
   localparam int DRAIN_CYCLES = 4;

   localparam logic [7:0] DIRECTED_SAMPLES [24] = '{
      8'h00, 8'h18, 8'h0C, 8'h30, 8'h06, 8'h60, 8'h03, 8'hC0,
      8'h01, 8'h80, 8'h00, 8'h24, 8'hFF, 8'h81, 8'h55, 8'hAA,
      8'h0E, 8'h70, 8'h3C, 8'h07, 8'hE0, 8'h42, 8'h1C, 8'h00
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [7:0]               req_sensor_bits = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [SPEED_W-1:0]       rsp_left_drive;
   logic [SPEED_W-1:0]       rsp_right_drive;
   logic signed [ERR_W-1:0]  rsp_line_error;
   logic signed [CTRL_W-1:0] rsp_control_value;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_write_data = '0;

   // Controller copy: registers and state as the block should hold them.
   logic [SPEED_W-1:0] drive_speed = REF_SPEED_RESET;
   logic [GAIN_W-1:0]  kp_halves = PROP_GAIN_RESET;
   logic [GAIN_W-1:0]  ki_halves = INTEG_GAIN_RESET;
   logic [GAIN_W-1:0]  kd_halves = DERIV_GAIN_RESET;
   error_type          held_error = '0;
   error_type          prior_error = '0;
   longint             error_sum = 0;

   logic [7:0]        sample_queue [$];
   result_type        steering_expected [$];
   int                mismatch_count = 0;
   int                burst_left = 0;
   int                gap_left = 0;
   int                stall_left = 0;
   stall_pattern_type stall_mode = STALL_NONE;

   line_sensor_pid_steering dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sensor_bits   (req_sensor_bits),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_left_drive    (rsp_left_drive),
      .rsp_right_drive   (rsp_right_drive),
      .rsp_line_error    (rsp_line_error),
      .rsp_control_value (rsp_control_value),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #1 clock = ~clock;

   function automatic longint limit_to(input longint value, input longint lo, input longint hi);
      if (value < lo) return lo;
      if (value > hi) return hi;
      return value;
   endfunction

   function automatic result_type compute_steering(input logic [7:0] sensors);
      error_type  e;
      bit         matched;
      longint     speed_l;
      longint     sum_max;
      longint     p_term;
      longint     i_term;
      longint     d_term;
      longint     control;
      longint     left_ctrl;
      longint     right_ctrl;
      result_type r;
      matched = 1'b1;
      if (sensors[4] && sensors[3]) e = 4'sd0;
      else if (sensors[3] && sensors[2]) e = -4'sd1;
      else if (sensors[4] && sensors[5]) e = 4'sd1;
      else if (sensors[2] && sensors[1]) e = -4'sd1;
      else if (sensors[5] && sensors[6]) e = 4'sd1;
      else if (sensors[1] && sensors[0]) e = -4'sd3;
      else if (sensors[6] && sensors[7]) e = 4'sd3;
      else if (sensors[0]) e = -4'sd4;
      else if (sensors[7]) e = 4'sd4;
      else begin
         matched = 1'b0;
         e = held_error;
      end
      if (matched) held_error = e;
      speed_l = longint'(drive_speed);
      r.left_drive = drive_speed;
      r.right_drive = drive_speed;
      r.line_error = e;
      r.control_value = '0;
      if (e != 0) begin
         sum_max = (longint'(1) << (SUM_WIDTH - 1)) - 1;
         error_sum = limit_to(error_sum + longint'(e), -sum_max - 1, sum_max);
         p_term = longint'(kp_halves) * longint'(e) / 2;
         i_term = longint'(ki_halves) * error_sum / 2;
         d_term = longint'(kd_halves) * (longint'(e) - longint'(prior_error)) / 2;
         prior_error = e;
         control = limit_to(p_term + i_term + d_term, -32768, 32767);
         left_ctrl = (control > speed_l) ? speed_l : control;
         right_ctrl = (control < -speed_l) ? -speed_l : control;
         r.left_drive = 8'(limit_to(speed_l - left_ctrl, 0, 255));
         r.right_drive = 8'(limit_to(speed_l + right_ctrl, 0, 255));
         r.control_value = control[CTRL_W-1:0];
      end
      return r;
   endfunction

   // Mostly a line of one to three adjacent sensors, plus stray bits, lost line and noise.
   function automatic logic [7:0] line_sample();
      int width;
      int pos;
      logic [7:0] bits;
      width = $urandom_range(1, 3);
      pos = $urandom_range(0, 8 - width);
      bits = 8'((32'd1 << width) - 1) << pos;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return bits;
         6: return bits | (8'd1 << $urandom_range(0, 7));
         7: return 8'h00;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatch_count < 40) begin
         $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
      end
      mismatch_count++;
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_REF_SPEED:  drive_speed = value[SPEED_W-1:0];
         CSR_PROP_GAIN:  kp_halves = value;
         CSR_INTEG_GAIN: ki_halves = value;
         CSR_DERIV_GAIN: kd_halves = value;
         default: ;
      endcase
   endtask

   task automatic set_controller(input logic [CSR_DATA_W-1:0] speed, input logic [GAIN_W-1:0] kp,
                                 input logic [GAIN_W-1:0] ki, input logic [GAIN_W-1:0] kd);
      write_register(CSR_REF_SPEED, speed);
      write_register(CSR_PROP_GAIN, kp);
      write_register(CSR_INTEG_GAIN, ki);
      write_register(CSR_DERIV_GAIN, kd);
   endtask

   task automatic wait_for_drain();
      do @(negedge clock);
      while (sample_queue.size() != 0 || req_valid || steering_expected.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            steering_expected.push_back(compute_steering(req_sensor_bits));
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 || sample_queue.size() == 0) begin
               req_valid <= 1'b0;
               if (gap_left > 0) gap_left--;
            end else begin
               req_valid <= 1'b1;
               req_sensor_bits <= sample_queue.pop_front();
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (steering_expected.size() == 0) begin
               report_mismatch("result beat with none pending", longint'(rsp_left_drive), -1);
            end else begin
               want = steering_expected.pop_front();
               if (rsp_left_drive !== want.left_drive)
                  report_mismatch("left_drive", longint'(rsp_left_drive),
                                  longint'(want.left_drive));
               if (rsp_right_drive !== want.right_drive)
                  report_mismatch("right_drive", longint'(rsp_right_drive),
                                  longint'(want.right_drive));
               if (rsp_line_error !== want.line_error)
                  report_mismatch("line_error", longint'(rsp_line_error),
                                  longint'(want.line_error));
               if (rsp_control_value !== want.control_value)
                  report_mismatch("control_value", longint'(rsp_control_value),
                                  longint'(want.control_value));
            end
         end
         if (stall_left <= 0) begin
            stall_mode = stall_pattern_type'($urandom_range(0, 3));
            stall_left = $urandom_range(8, 64);
         end
         stall_left--;
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_SAMPLES[k]) sample_queue.push_back(DIRECTED_SAMPLES[k]);
      wait_for_drain();

      set_controller(9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF);
      repeat (EXTREME_ITEMS) sample_queue.push_back(line_sample());
      wait_for_drain();

      set_controller(9'h000, 9'h000, 9'h000, 9'h000);
      repeat (EXTREME_ITEMS) sample_queue.push_back(line_sample());
      wait_for_drain();

      repeat (RANDOM_PHASES) begin
         set_controller(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                        9'($urandom_range(0, 31)), 9'($urandom_range(0, 511)));
         repeat (ITEMS_PER_PHASE) sample_queue.push_back(line_sample());
         wait_for_drain();
      end

      // Push the error sum well up with hard edge errors, then back down through zero.
      set_controller(9'($urandom_range(0, 255)), 9'($urandom_range(0, 511)), 9'h1FF,
                     9'($urandom_range(0, 511)));
      repeat (SUM_UP_ITEMS) sample_queue.push_back($urandom_range(0, 1) ? 8'h80 : 8'hA8);
      repeat (SUM_DOWN_ITEMS) sample_queue.push_back($urandom_range(0, 1) ? 8'h01 : 8'h15);
      wait_for_drain();

      if (mismatch_count == 0 && steering_expected.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
